>>> rtl/multichannel_sample_statistics_defines.svh
// Assertion macros shared by the sample statistics RTL.
`ifndef MULTICHANNEL_SAMPLE_STATISTICS_DEFINES_SVH
`define MULTICHANNEL_SAMPLE_STATISTICS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSTAT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSTAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sstat_pkg.sv
// Types and constants shared by the sample statistics modules.
`default_nettype none

package sstat_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int THRESH_W  = 24;
  localparam int SQUARE_W  = 2 * SAMPLE_W;
  localparam int SUM_W     = 44;
  localparam int SQSUM_W   = 64;
  localparam int CNT_OUT_W = 21;
  localparam int CH_OUT_W  = 3;

  localparam logic [THRESH_W-1:0] CLIP_RESET = 24'd8380000;

  // Depth of the queue between front and back; power of two.
  localparam int QUEUE_DEPTH = 4;

  // Result word layout, lowest bit first.
  localparam int OFS_CH     = 0;
  localparam int OFS_MIN    = OFS_CH + CH_OUT_W;
  localparam int OFS_MAX    = OFS_MIN + SAMPLE_W;
  localparam int OFS_SUM    = OFS_MAX + SAMPLE_W;
  localparam int OFS_SQ     = OFS_SUM + SUM_W;
  localparam int OFS_PEAK   = OFS_SQ + SQSUM_W;
  localparam int OFS_ZERO   = OFS_PEAK + SAMPLE_W;
  localparam int OFS_CHANGE = OFS_ZERO + CNT_OUT_W;
  localparam int OFS_CLIP   = OFS_CHANGE + CNT_OUT_W;
  localparam int OFS_FRAME  = OFS_CLIP + CNT_OUT_W;
  localparam int OUT_BITS   = OFS_FRAME + CNT_OUT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // One classified sample as it travels from front to back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0]        mag;
    logic [SQUARE_W-1:0]        square;
    logic                       is_zero;
    logic                       is_clip;
  } lane_t;

  localparam int LANE_W = $bits(lane_t);

endpackage

`default_nettype wire

>>> rtl/sstat_front.sv
// Front end: clip threshold register and per-channel sample classification.
`default_nettype none

module sstat_front #(
  parameter int CHANNELS    = 7,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [sstat_pkg::THRESH_W-1:0]           cfg_wdata,
  input  logic [CHANNELS*sstat_pkg::SAMPLE_W-1:0]  tdata,
  output sstat_pkg::lane_t [CHANNELS-1:0]          lanes
);
  import sstat_pkg::*;

  localparam int SHIFT = SAMPLE_W - SAMPLE_BITS;

  logic [THRESH_W-1:0] clip_threshold;

  logic [SAMPLE_W-1:0]        aligned [CHANNELS];
  logic signed [SAMPLE_W-1:0] smp     [CHANNELS];
  logic [SAMPLE_W-1:0]        mag     [CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_threshold <= CLIP_RESET;
    end else if (cfg_we) begin
      clip_threshold <= cfg_wdata;
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      // keep the low SAMPLE_BITS bits and sign-extend them
      aligned[c] = tdata[c*SAMPLE_W +: SAMPLE_W] << SHIFT;
      smp[c]     = $signed(aligned[c]) >>> SHIFT;
      // negating the most negative sample gives 2^(w-1), still fits unsigned
      mag[c]     = smp[c][SAMPLE_W-1] ? SAMPLE_W'(-smp[c]) : smp[c];

      lanes[c].sample  = smp[c];
      lanes[c].mag     = mag[c];
      lanes[c].square  = SQUARE_W'(mag[c]) * SQUARE_W'(mag[c]);
      lanes[c].is_zero = (smp[c] == '0);
      lanes[c].is_clip = (mag[c] >= clip_threshold);
    end
  end

endmodule

`default_nettype wire

>>> rtl/sstat_queue.sv
// Short register queue between the front end and the accumulator.
`default_nettype none

module sstat_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

  // pointers wrap on their own since DEPTH is a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/sstat_back.sv
// Back end: per-channel accumulators and the report sequencer.
`default_nettype none

module sstat_back #(
  parameter int CHANNELS    = 7,
  parameter int MAX_FRAMES  = 1048576,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  output logic                               q_ready,
  input  sstat_pkg::lane_t [CHANNELS-1:0]    q_lanes,
  input  logic                               q_last,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [sstat_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast,
  output logic                               reporting
);
  import sstat_pkg::*;

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int SQX_W   = SQSUM_W + 1;
  localparam logic [CH_W-1:0]  LAST_CH     = CH_W'(CHANNELS - 1);
  localparam logic [CNT_W-1:0] FRAME_LIMIT = CNT_W'(MAX_FRAMES);
  localparam logic signed [SAMPLE_W-1:0] SMAX = SAMPLE_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SAMPLE_W-1:0] SMIN = ~SMAX;

  logic signed [SAMPLE_W-1:0] min_st    [CHANNELS];
  logic signed [SAMPLE_W-1:0] max_st    [CHANNELS];
  logic signed [SUM_W-1:0]    sum_st    [CHANNELS];
  logic [SQSUM_W-1:0]         sq_st     [CHANNELS];
  logic [SAMPLE_W-1:0]        peak_st   [CHANNELS];
  logic [CNT_W-1:0]           zero_st   [CHANNELS];
  logic [CNT_W-1:0]           change_st [CHANNELS];
  logic [CNT_W-1:0]           clip_st   [CHANNELS];
  logic signed [SAMPLE_W-1:0] prev_st   [CHANNELS];
  logic [CNT_W-1:0]           frames;

  logic [SQX_W-1:0]      sq_wide [CHANNELS];
  logic [SQSUM_W-1:0]    sq_next [CHANNELS];
  logic                  q_pop;
  logic                  first;
  logic                  full;
  logic [CH_W-1:0]       rpt_ch;
  logic                  load_out;
  logic                  rpt_final;
  logic [OUT_DATA_W-1:0] rpt_word;

  assign q_ready   = !reporting;
  assign q_pop     = q_valid && q_ready;
  assign first     = (frames == '0);
  assign full      = (frames == FRAME_LIMIT);
  assign load_out  = reporting && (!m_axis_tvalid || m_axis_tready);
  assign rpt_final = (rpt_ch == LAST_CH);

  // saturating sum of squares
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      sq_wide[c] = {1'b0, sq_st[c]} + SQX_W'(q_lanes[c].square);
      sq_next[c] = sq_wide[c][SQSUM_W] ? '1 : sq_wide[c][SQSUM_W-1:0];
    end
  end

  always_comb begin
    rpt_word = '0;
    rpt_word[OFS_CH     +: CH_OUT_W]  = CH_OUT_W'(rpt_ch);
    rpt_word[OFS_MIN    +: SAMPLE_W]  = min_st[rpt_ch];
    rpt_word[OFS_MAX    +: SAMPLE_W]  = max_st[rpt_ch];
    rpt_word[OFS_SUM    +: SUM_W]     = sum_st[rpt_ch];
    rpt_word[OFS_SQ     +: SQSUM_W]   = sq_st[rpt_ch];
    rpt_word[OFS_PEAK   +: SAMPLE_W]  = peak_st[rpt_ch];
    rpt_word[OFS_ZERO   +: CNT_OUT_W] = CNT_OUT_W'(zero_st[rpt_ch]);
    rpt_word[OFS_CHANGE +: CNT_OUT_W] = CNT_OUT_W'(change_st[rpt_ch]);
    rpt_word[OFS_CLIP   +: CNT_OUT_W] = CNT_OUT_W'(clip_st[rpt_ch]);
    rpt_word[OFS_FRAME  +: CNT_OUT_W] = CNT_OUT_W'(frames);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reporting     <= 1'b0;
      rpt_ch        <= '0;
      m_axis_tvalid <= 1'b0;
      frames        <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        min_st[c]    <= SMAX;
        max_st[c]    <= SMIN;
        sum_st[c]    <= '0;
        sq_st[c]     <= '0;
        peak_st[c]   <= '0;
        zero_st[c]   <= '0;
        change_st[c] <= '0;
        clip_st[c]   <= '0;
        prev_st[c]   <= '0;
      end
    end else begin
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      // frames past the capture limit are dropped, their last mark still counts
      if (q_pop && !full) begin
        frames <= frames + CNT_W'(1);
        for (int c = 0; c < CHANNELS; c++) begin
          if (q_lanes[c].sample < min_st[c]) min_st[c] <= q_lanes[c].sample;
          if (q_lanes[c].sample > max_st[c]) max_st[c] <= q_lanes[c].sample;
          if (q_lanes[c].mag > peak_st[c])   peak_st[c] <= q_lanes[c].mag;
          sum_st[c] <= sum_st[c] + SUM_W'(q_lanes[c].sample);
          sq_st[c]  <= sq_next[c];
          if (q_lanes[c].is_zero) zero_st[c] <= zero_st[c] + CNT_W'(1);
          if (q_lanes[c].is_clip) clip_st[c] <= clip_st[c] + CNT_W'(1);
          if (!first && (q_lanes[c].sample != prev_st[c])) begin
            change_st[c] <= change_st[c] + CNT_W'(1);
          end
          prev_st[c] <= q_lanes[c].sample;
        end
      end

      if (q_pop && q_last) begin
        reporting <= 1'b1;
      end

      // no pop happens while reporting, so clearing never meets an update
      if (load_out) begin
        if (rpt_final) begin
          reporting <= 1'b0;
          rpt_ch    <= '0;
          frames    <= '0;
          for (int c = 0; c < CHANNELS; c++) begin
            min_st[c]    <= SMAX;
            max_st[c]    <= SMIN;
            sum_st[c]    <= '0;
            sq_st[c]     <= '0;
            peak_st[c]   <= '0;
            zero_st[c]   <= '0;
            change_st[c] <= '0;
            clip_st[c]   <= '0;
            prev_st[c]   <= '0;
          end
        end else begin
          rpt_ch <= rpt_ch + CH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= rpt_word;
      m_axis_tlast <= rpt_final;
    end
  end

endmodule

`default_nettype wire

>>> rtl/multichannel_sample_statistics.sv
// Multichannel sample statistics: per-channel min, max, sums and counts over a capture.
//
// Input stream: one frame per request, CHANNELS signed samples in tdata, tlast
// marks the final frame of a capture. Frames are accepted one per cycle while
// the queue has room; the front end classifies each sample (magnitude, square,
// zero, clip) and writes the frame into a 4-entry queue that feeds the accumulators.
// Output stream: on the final frame, one report per channel, channel 0 first,
// tlast on the last channel. When the final frame leaves the queue, a reporting
// flag is set and then the first report loads into the output register; after
// that, one report per cycle while the receiver is ready. While reports go out
// the accumulators take no frames; input keeps flowing into the queue until it
// fills, then s_axis_tready drops. A stalled receiver holds the current report
// in the output register. Once the last report is loaded into the output
// register the accumulators clear and the next capture starts.
// cfg_we/cfg_wdata write the clip threshold; write it only while idle.
// Reset (rst, synchronous) sets the clip threshold to 8380000 and clears all
// accumulators at once, with no clearing pass.
`default_nettype none

`include "multichannel_sample_statistics_defines.svh"

module multichannel_sample_statistics #(
  parameter int CHANNELS    = 7,
  parameter int MAX_FRAMES  = 1048576,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [sstat_pkg::THRESH_W-1:0]          cfg_wdata,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // sample_ch0, sample_ch1, ... one SAMPLE_W-bit field per channel
  input  logic [CHANNELS*sstat_pkg::SAMPLE_W-1:0] s_axis_tdata,
  input  logic                                    s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // channel, minimum, maximum, sample_sum, square_sum, peak, zero_count,
  // change_count, clip_count, frame_count, zero fill
  output logic [sstat_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                    m_axis_tlast
);
  import sstat_pkg::*;

  localparam int ENTRY_W = CHANNELS * LANE_W + 1;

  lane_t [CHANNELS-1:0] lanes_in;
  lane_t [CHANNELS-1:0] q_lanes;
  logic [ENTRY_W-1:0]   q_in;
  logic [ENTRY_W-1:0]   q_out;
  logic                 q_valid;
  logic                 q_ready;
  logic                 q_last;
  logic                 reporting;

  sstat_front #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tdata     (s_axis_tdata),
    .lanes     (lanes_in)
  );

  assign q_in = {s_axis_tlast, lanes_in};

  sstat_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (q_in),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_out)
  );

  assign q_last  = q_out[ENTRY_W-1];
  assign q_lanes = q_out[ENTRY_W-2:0];

  sstat_back #(
    .CHANNELS    (CHANNELS),
    .MAX_FRAMES  (MAX_FRAMES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_lanes       (q_lanes),
    .q_last        (q_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .reporting     (reporting)
  );

  `SSTAT_ASSERT_NEXT(a_last_starts_report, clk, rst, q_valid && q_ready && q_last, reporting, "final frame did not start a report")
  `SSTAT_ASSERT_SAME(a_tlast_on_final_channel, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tdata[CH_OUT_W-1:0] == CH_OUT_W'(CHANNELS - 1), "tlast on a channel other than the final one")
  `SSTAT_ASSERT_NEXT(a_no_report_no_output, clk, rst, !m_axis_tvalid && !reporting, !m_axis_tvalid, "output valid without a report in progress")
  `SSTAT_ASSERT_NEXT(a_report_fills_output, clk, rst, reporting && !m_axis_tvalid, m_axis_tvalid, "report did not load the empty output register")

endmodule

`default_nettype wire

>>> sim/multichannel_sample_statistics_test.sv
// Self-checking testbench for the multichannel sample statistics block.
`timescale 1ns / 100ps

localparam int LANES      = 7;
localparam int MAX_FRAMES = 1048576;

typedef logic [LANES*sstat_pkg::SAMPLE_W-1:0] frame_t;

typedef struct packed {
  logic [2:0]         channel;
  logic signed [23:0] minimum;
  logic signed [23:0] maximum;
  logic signed [43:0] sample_sum;
  logic [63:0]        square_sum;
  logic [23:0]        peak;
  logic [20:0]        zero_count;
  logic [20:0]        change_count;
  logic [20:0]        clip_count;
  logic [20:0]        frame_count;
  logic               last_channel;
} report_t;

// Tracks per-channel capture statistics and the reports still owed by the block.
class capture_stats_tracker;
  logic [23:0]        clip_level;
  logic signed [23:0] lo [LANES];
  logic signed [23:0] hi [LANES];
  logic signed [23:0] prev [LANES];
  logic signed [43:0] total [LANES];
  logic [63:0]        energy [LANES];
  logic [23:0]        peak [LANES];
  logic [20:0]        zeros [LANES];
  logic [20:0]        changes [LANES];
  logic [20:0]        clips [LANES];
  int                 frames;
  report_t            expected_reports[$];
  int                 failures;

  function new();
    clip_level = sstat_pkg::CLIP_RESET;
    failures = 0;
    clear_capture();
  endfunction

  function void clear_capture();
    for (int c = 0; c < LANES; c++) begin
      lo[c] = 24'sh7fffff;
      hi[c] = 24'sh800000;
      prev[c] = '0;
      total[c] = '0;
      energy[c] = '0;
      peak[c] = '0;
      zeros[c] = '0;
      changes[c] = '0;
      clips[c] = '0;
    end
    frames = 0;
  endfunction

  function void set_clip(logic [23:0] level);
    clip_level = level;
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction

  function void note_frame(frame_t frame, logic last);
    logic signed [23:0] v;
    logic [23:0]        mag;
    logic [63:0]        sq;
    logic [64:0]        acc;
    logic               first;
    report_t            rep;
    // a full capture drops frames but still honors the last mark
    if (frames < MAX_FRAMES) begin
      first = (frames == 0);
      for (int c = 0; c < LANES; c++) begin
        v = frame[c*sstat_pkg::SAMPLE_W +: sstat_pkg::SAMPLE_W];
        mag = v[23] ? (~v + 24'd1) : v;
        sq = {40'd0, mag} * {40'd0, mag};
        if (v < lo[c]) lo[c] = v;
        if (v > hi[c]) hi[c] = v;
        if (mag > peak[c]) peak[c] = mag;
        total[c] = total[c] + {{20{v[23]}}, v};
        acc = {1'b0, energy[c]} + {1'b0, sq};
        energy[c] = acc[64] ? '1 : acc[63:0];
        if (v == 0) zeros[c]++;
        if (!first && v != prev[c]) changes[c]++;
        if (mag >= clip_level) clips[c]++;
        prev[c] = v;
      end
      frames++;
    end
    if (!last) return;
    for (int c = 0; c < LANES; c++) begin
      rep.channel = c[2:0];
      rep.minimum = lo[c];
      rep.maximum = hi[c];
      rep.sample_sum = total[c];
      rep.square_sum = energy[c];
      rep.peak = peak[c];
      rep.zero_count = zeros[c];
      rep.change_count = changes[c];
      rep.clip_count = clips[c];
      rep.frame_count = frames[20:0];
      rep.last_channel = (c == LANES - 1);
      expected_reports.push_back(rep);
    end
    clear_capture();
  endfunction

  function void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  function void check_report(logic [sstat_pkg::OUT_DATA_W-1:0] word, logic tlast);
    report_t got;
    report_t want;
    got.channel = word[sstat_pkg::OFS_CH +: sstat_pkg::CH_OUT_W];
    got.minimum = word[sstat_pkg::OFS_MIN +: sstat_pkg::SAMPLE_W];
    got.maximum = word[sstat_pkg::OFS_MAX +: sstat_pkg::SAMPLE_W];
    got.sample_sum = word[sstat_pkg::OFS_SUM +: sstat_pkg::SUM_W];
    got.square_sum = word[sstat_pkg::OFS_SQ +: sstat_pkg::SQSUM_W];
    got.peak = word[sstat_pkg::OFS_PEAK +: sstat_pkg::SAMPLE_W];
    got.zero_count = word[sstat_pkg::OFS_ZERO +: sstat_pkg::CNT_OUT_W];
    got.change_count = word[sstat_pkg::OFS_CHANGE +: sstat_pkg::CNT_OUT_W];
    got.clip_count = word[sstat_pkg::OFS_CLIP +: sstat_pkg::CNT_OUT_W];
    got.frame_count = word[sstat_pkg::OFS_FRAME +: sstat_pkg::CNT_OUT_W];
    got.last_channel = tlast;
    if (expected_reports.size() == 0) begin
      $error("report for channel %0d with no request pending", got.channel);
      failures++;
      return;
    end
    want = expected_reports.pop_front();
    check_field("channel", want.channel, got.channel);
    check_field("minimum", want.minimum, got.minimum);
    check_field("maximum", want.maximum, got.maximum);
    check_field("sample_sum", want.sample_sum, got.sample_sum);
    check_field("square_sum", want.square_sum, got.square_sum);
    check_field("peak", want.peak, got.peak);
    check_field("zero_count", want.zero_count, got.zero_count);
    check_field("change_count", want.change_count, got.change_count);
    check_field("clip_count", want.clip_count, got.clip_count);
    check_field("frame_count", want.frame_count, got.frame_count);
    check_field("last_channel", want.last_channel, got.last_channel);
  endfunction
endclass

module multichannel_sample_statistics_test;

  localparam int SETTLE_CYCLES = sstat_pkg::QUEUE_DEPTH + 8;
  localparam int HOLD_CYCLES   = 120;

  logic                                clk;
  logic                                rst;
  logic                                cfg_we;
  logic [sstat_pkg::THRESH_W-1:0]      cfg_wdata;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  frame_t                              s_axis_tdata;
  logic                                s_axis_tlast;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  logic [sstat_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
  logic                                m_axis_tlast;

  capture_stats_tracker stats;
  logic                 no_idle;
  logic                 hold_armed;
  int                   hold_left;
  logic [23:0]          clip_level;
  logic [23:0]          last_sent [LANES];

  multichannel_sample_statistics u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // Report sink: random idling, plus one long hold-off once armed.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else if (hold_armed && m_axis_tvalid) begin
        hold_armed = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = no_idle || ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      stats.check_report(m_axis_tdata, m_axis_tlast);
  end

  // Leaves tvalid high after acceptance; the next negedge either reloads or drops it.
  task automatic send_frame(input frame_t frame, input logic last);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 34) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = frame;
    s_axis_tlast = last;
    do @(posedge clk); while (!s_axis_tready);
    stats.note_frame(frame, last);
    for (int c = 0; c < LANES; c++)
      last_sent[c] = frame[c*sstat_pkg::SAMPLE_W +: sstat_pkg::SAMPLE_W];
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (stats.pending() != 0) @(negedge clk);
  endtask

  task automatic write_clip(input logic [23:0] level);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = level;
    stats.set_clip(level);
    clip_level = level;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic frame_t uniform(input logic [23:0] v);
    return {LANES{v}};
  endfunction

  function automatic logic [23:0] pick_sample(input logic [23:0] prev);
    logic [23:0] m;
    case ($urandom_range(9))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'h000000;
      3: return prev;
      4: begin
        // right around the clip level, either sign
        m = clip_level + 24'($urandom_range(2)) - 24'd1;
        return $urandom_range(1) ? (~m + 24'd1) : m;
      end
      5: begin
        m = 24'($urandom_range(1, 255));
        return $urandom_range(1) ? (~m + 24'd1) : m;
      end
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    for (int c = 0; c < LANES; c++)
      f[c*sstat_pkg::SAMPLE_W +: sstat_pkg::SAMPLE_W] = pick_sample(last_sent[c]);
    return f;
  endfunction

  initial begin
    frame_t f;
    int     len;
    int     random_frames;
    int     capture_no;
    logic   [23:0] level;

    stats = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    no_idle = 1'b0;
    hold_armed = 1'b0;
    hold_left = 0;
    clip_level = sstat_pkg::CLIP_RESET;
    for (int c = 0; c < LANES; c++) last_sent[c] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // one-frame capture: extremes and both sides of the default clip level
    f = {24'hffffff, 24'd8379999, 24'hfb22a0, 24'd8380000,
         24'h000000, 24'h7fffff, 24'h800000};
    send_frame(f, 1'b1);

    // repeated frame counts no change; alternating bit patterns
    send_frame(uniform(24'h555555), 1'b0);
    send_frame(uniform(24'haaaaaa), 1'b0);
    send_frame(uniform(24'haaaaaa), 1'b0);
    send_frame(uniform(24'h000000), 1'b0);
    send_frame(uniform(24'h800000), 1'b0);
    send_frame(uniform(24'h7fffff), 1'b1);

    // clip level zero: every sample clips, zeros included
    write_clip(24'd0);
    send_frame(uniform(24'h000000), 1'b0);
    send_frame(uniform(24'h000001), 1'b0);
    send_frame(uniform(24'hffffff), 1'b1);

    // top clip level: only full-scale negative reaches it
    write_clip(24'h800000);
    send_frame(uniform(24'h800000), 1'b0);
    send_frame(uniform(24'h7fffff), 1'b1);

    // long sink hold-off while frames keep coming, so the input stalls
    write_clip(24'($urandom));
    hold_armed = 1'b1;
    no_idle = 1'b1;
    for (int k = 0; k < 30; k++)
      send_frame(random_frame(), (k % 3) == 2);
    no_idle = 1'b0;
    wait_drained();

    random_frames = 0;
    capture_no = 0;
    while (random_frames < 385) begin
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: level = 24'd0;
          1: level = 24'h800000;
          2: level = sstat_pkg::CLIP_RESET;
          default: level = 24'($urandom);
        endcase
        write_clip(level);
      end
      no_idle = (capture_no >= 20 && capture_no < 26);
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        send_frame(random_frame(), k == len - 1);
        random_frames++;
      end
      if ($urandom_range(9) == 0) wait_drained();
      capture_no++;
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (stats.failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> multichannel_sample_statistics.f
+incdir+rtl
rtl/sstat_pkg.sv
rtl/sstat_front.sv
rtl/sstat_queue.sv
rtl/sstat_back.sv
rtl/multichannel_sample_statistics.sv
sim/multichannel_sample_statistics_test.sv
